// File: rtl/qte_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and latencies of the quaternion to euler angles unit
// no dependencies

package qte_pkg;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               zero_quaternion;
  } euler_out_t;

  localparam int OUT_W    = 16;
  localparam int OPD_W    = 64;
  localparam int NORM_W   = 30;
  localparam int CORDIC_W = 34;
  localparam int ANG_W    = 28;
  localparam int RND_SH   = 11;
  localparam int RND_HALF = 1024;

  localparam int CORDIC_STEPS    = 24;
  localparam int STEPS_PER_STAGE = 2;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  localparam logic signed [ANG_W-1:0] ANG_PI = 28'sd52707179;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
    28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
    28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
    28'sd256,      28'sd128,     28'sd64,      28'sd32,
    28'sd16,       28'sd8,       28'sd4,       28'sd2
  };

  localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

  localparam int SQRT_W         = 64;
  localparam int SQRT_ITERS     = SQRT_W / 2;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = SQRT_ITERS / SQRT_PER_STAGE;

  // stage counts
  localparam int ATAN_LAT  = 5 + CORDIC_STAGES + 1;
  localparam int FRONT_LAT = 8;
  localparam int ASIN_LAT  = 4;
  localparam int ANG_DLY   = ASIN_LAT + SQRT_STAGES;
  localparam int PIPE_LAT  = FRONT_LAT + ANG_DLY + ATAN_LAT;

endpackage

// File: rtl/quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// quaternion to zyx euler angles, fully pipelined, depends on qte_pkg, qte_isqrt, qte_atan2
// 46 register stages from input transfer to result valid (front end 8, asin prep 4,
// square root 16, atan2 18); throughput one quaternion per cycle unless stalled
// an output skid register holds one result under stall, then the pipeline freezes
// reset clears the valid shift register and the skid valid flag only

module quaternion_to_euler_angles_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  qte_pkg::quat_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output qte_pkg::euler_out_t  out_data_o
);
  import qte_pkg::*;

  logic en;
  logic skid_vld_q, skid_vld_d;
  euler_out_t skid_q, last_res;
  logic [PIPE_LAT-1:0] vld_q, zq_q;

  logic signed [31:0] q1_q [4];
  logic [31:0] mag2_q [4];
  logic [31:0] mag3_q [4];
  logic [31:0] mag4_q [4];
  logic [3:0]  sgn2_q, sgn3_q, sgn4_q;
  logic [31:0] max3_q, max_c, m01, m23;
  logic [5:0]  len4_q, len_c;
  logic [31:0] nm_c [4];
  logic signed [NORM_W:0] qn5_q [4];
  logic signed [NORM_W:0] tn_c [4];

  logic signed [2*NORM_W+1:0] p_ww_q, p_xx_q, p_yy_q, p_zz_q, p_wy_q;
  logic signed [2*NORM_W+1:0] p_zx_q, p_wz_q, p_xy_q, p_wx_q, p_yz_q;
  logic signed [OPD_W-1:0] sa7_q, sb7_q, sd7_q, se7_q, sf7_q, sg7_q, sh7_q;
  logic signed [OPD_W-1:0] n8_q, yx8_q, rx8_q, s8_q, ya8_q, ry8_q;
  logic signed [OPD_W-1:0] n9_q, sc9_q, sc_c;
  logic [OPD_W-1:0] smag_c;
  logic [31:0] np10_q;
  logic signed [31:0] sp10_q, sp11_q, sp12_q, sp_c;
  logic [63:0] npsq11_q, v12_q;
  logic signed [63:0] spsq11_q;
  logic signed [31:0] spd_q [SQRT_STAGES];
  logic [31:0] root;

  logic signed [OUT_W-1:0] pitch_a, yaw_a, roll_a;
  logic signed [OUT_W-1:0] yawd_q [ANG_DLY];
  logic signed [OUT_W-1:0] rolld_q [ANG_DLY];

  assign en         = ~skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // output skid
  always_comb begin
    skid_vld_d = skid_vld_q;
    if (skid_vld_q && !out_stall_i) begin
      skid_vld_d = 1'b0;
    end else if (!skid_vld_q && vld_q[PIPE_LAT-1] && out_stall_i) begin
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
      if (en) vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && out_stall_i) skid_q <= last_res;
  end

  always_comb begin
    last_res.zero_quaternion = zq_q[PIPE_LAT-1];
    last_res.pitch_angle     = zq_q[PIPE_LAT-1] ? '0 : pitch_a;
    last_res.yaw_angle       = zq_q[PIPE_LAT-1] ? '0 : yawd_q[ANG_DLY-1];
    last_res.roll_angle      = zq_q[PIPE_LAT-1] ? '0 : rolld_q[ANG_DLY-1];
  end

  assign out_valid_o = skid_vld_q | vld_q[PIPE_LAT-1];
  assign out_data_o  = skid_vld_q ? skid_q : last_res;

  // front end combinational parts
  always_comb begin
    m01   = (mag2_q[0] > mag2_q[1]) ? mag2_q[0] : mag2_q[1];
    m23   = (mag2_q[2] > mag2_q[3]) ? mag2_q[2] : mag2_q[3];
    max_c = (m01 > m23) ? m01 : m23;
  end

  always_comb begin
    len_c = '0;
    for (int b = 0; b < 32; b++) begin
      if (max3_q[b]) len_c = 6'(b + 1);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (len4_q > 6'(NORM_W)) begin
        nm_c[i] = mag4_q[i] >> (len4_q - 6'(NORM_W));
      end else begin
        nm_c[i] = mag4_q[i] << (6'(NORM_W) - len4_q);
      end
      tn_c[i] = $signed({1'b0, nm_c[i][NORM_W-1:0]});
    end
  end

  always_comb begin
    if (s8_q > n8_q) begin
      sc_c = n8_q;
    end else if (s8_q < -n8_q) begin
      sc_c = -n8_q;
    end else begin
      sc_c = s8_q;
    end
  end

  always_comb begin
    smag_c = sc9_q[OPD_W-1] ? $unsigned(-sc9_q) : $unsigned(sc9_q);
    sp_c   = $signed({1'b0, smag_c[61:31]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zq_q <= {zq_q[PIPE_LAT-2:0], (in_data_i == '0)};

      q1_q[0] <= in_data_i.quat_w;
      q1_q[1] <= in_data_i.quat_x;
      q1_q[2] <= in_data_i.quat_y;
      q1_q[3] <= in_data_i.quat_z;

      for (int i = 0; i < 4; i++) begin
        mag2_q[i] <= q1_q[i][31] ? $unsigned(-q1_q[i]) : $unsigned(q1_q[i]);
        sgn2_q[i] <= q1_q[i][31];
        mag3_q[i] <= mag2_q[i];
        mag4_q[i] <= mag3_q[i];
        qn5_q[i]  <= sgn4_q[i] ? -tn_c[i] : tn_c[i];
      end
      sgn3_q <= sgn2_q;
      sgn4_q <= sgn3_q;
      max3_q <= max_c;
      len4_q <= len_c;

      p_ww_q <= qn5_q[0] * qn5_q[0];
      p_xx_q <= qn5_q[1] * qn5_q[1];
      p_yy_q <= qn5_q[2] * qn5_q[2];
      p_zz_q <= qn5_q[3] * qn5_q[3];
      p_wy_q <= qn5_q[0] * qn5_q[2];
      p_zx_q <= qn5_q[3] * qn5_q[1];
      p_wz_q <= qn5_q[0] * qn5_q[3];
      p_xy_q <= qn5_q[1] * qn5_q[2];
      p_wx_q <= qn5_q[0] * qn5_q[1];
      p_yz_q <= qn5_q[2] * qn5_q[3];

      sa7_q <= OPD_W'(p_ww_q) + OPD_W'(p_xx_q);
      sb7_q <= OPD_W'(p_yy_q) + OPD_W'(p_zz_q);
      sd7_q <= OPD_W'(p_ww_q) - OPD_W'(p_xx_q);
      se7_q <= OPD_W'(p_zz_q) - OPD_W'(p_yy_q);
      sf7_q <= OPD_W'(p_wy_q) - OPD_W'(p_zx_q);
      sg7_q <= OPD_W'(p_wz_q) + OPD_W'(p_xy_q);
      sh7_q <= OPD_W'(p_wx_q) + OPD_W'(p_yz_q);

      n8_q  <= sa7_q + sb7_q;
      yx8_q <= sa7_q - sb7_q;
      rx8_q <= sd7_q + se7_q;
      s8_q  <= sf7_q <<< 1;
      ya8_q <= sg7_q <<< 1;
      ry8_q <= sh7_q <<< 1;

      n9_q  <= n8_q;
      sc9_q <= sc_c;

      np10_q <= n9_q[62:31];
      sp10_q <= sc9_q[OPD_W-1] ? -sp_c : sp_c;

      npsq11_q <= np10_q * np10_q;
      spsq11_q <= sp10_q * sp10_q;
      sp11_q   <= sp10_q;

      v12_q  <= npsq11_q - $unsigned(spsq11_q);
      sp12_q <= sp11_q;

      spd_q[0]   <= sp12_q;
      yawd_q[0]  <= yaw_a;
      rolld_q[0] <= roll_a;
      for (int k = 1; k < SQRT_STAGES; k++) spd_q[k] <= spd_q[k-1];
      for (int k = 1; k < ANG_DLY; k++) begin
        yawd_q[k]  <= yawd_q[k-1];
        rolld_q[k] <= rolld_q[k-1];
      end
    end
  end

  qte_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (v12_q),
    .root_o (root)
  );

  qte_atan2 u_pitch (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (OPD_W'(spd_q[SQRT_STAGES-1])),
    .x_i   ($signed({32'd0, root})),
    .ang_o (pitch_a)
  );

  qte_atan2 u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ya8_q),
    .x_i   (yx8_q),
    .ang_o (yaw_a)
  );

  qte_atan2 u_roll (
    .clk_i (clk_i),
    .en_i  (en),
    .y_i   (ry8_q),
    .x_i   (rx8_q),
    .ang_o (roll_a)
  );

endmodule

// File: rtl/qte_isqrt.sv
`timescale 1ns / 1ps
// pipelined integer square root, two result bits per stage
// depends on qte_pkg

module qte_isqrt (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [qte_pkg::SQRT_W-1:0]      v_i,
  output logic [qte_pkg::SQRT_W/2-1:0]    root_o
);
  import qte_pkg::*;

  logic [SQRT_W-1:0] rem_q [SQRT_STAGES];
  logic [SQRT_W-1:0] r_q   [SQRT_STAGES];

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [SQRT_W-1:0] rem_in, r_in, rem_c, r_c, one_bit, trial;

    if (g == 0) begin : g_first
      assign rem_in = v_i;
      assign r_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign r_in   = r_q[g-1];
    end

    always_comb begin
      rem_c   = rem_in;
      r_c     = r_in;
      one_bit = '0;
      trial   = '0;
      for (int k = 0; k < SQRT_PER_STAGE; k++) begin
        one_bit = SQRT_W'(1) << (SQRT_W - 2 - 2 * (g * SQRT_PER_STAGE + k));
        trial   = r_c + one_bit;
        if (rem_c >= trial) begin
          rem_c = rem_c - trial;
          r_c   = (r_c >> 1) + one_bit;
        end else begin
          r_c = r_c >> 1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_c;
        r_q[g]   <= r_c;
      end
    end
  end

  assign root_o = r_q[SQRT_STAGES-1][SQRT_W/2-1:0];

endmodule

// File: rtl/qte_atan2.sv
`timescale 1ns / 1ps
// pipelined atan2: block scaling, quadrant fold, cordic vectoring, rounding to q3.13
// depends on qte_pkg

module qte_atan2 (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [qte_pkg::OPD_W-1:0]    y_i,
  input  logic signed [qte_pkg::OPD_W-1:0]    x_i,
  output logic signed [qte_pkg::OUT_W-1:0]    ang_o
);
  import qte_pkg::*;

  localparam int CHUNKS = OPD_W / 16;
  localparam int LEN_W  = $clog2(OPD_W + 1);
  localparam int RR_W   = ANG_W + 1 - RND_SH;

  // scaling stages
  logic [OPD_W-1:0] mx1_q, my1_q, mx2_q, my2_q, mx3_q, my3_q;
  logic sx1_q, sy1_q, sx2_q, sy2_q, sx3_q, sy3_q;
  logic [CHUNKS-1:0] nz2_q;
  logic [3:0] pos2_q [CHUNKS];
  logic [LEN_W-1:0] len3_q;
  logic signed [NORM_W:0] xs4_q, ys4_q;
  logic zr4_q;

  logic [OPD_W-1:0] orv;
  logic [CHUNKS-1:0] nz_c;
  logic [3:0] pos_c [CHUNKS];
  logic [LEN_W-1:0] len_c;
  logic [OPD_W-1:0] shx, shy;
  logic signed [NORM_W:0] xv, yv;

  // cordic stages
  logic signed [CORDIC_W-1:0] xc_q [CORDIC_STAGES+1];
  logic signed [CORDIC_W-1:0] yc_q [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0]    zc_q [CORDIC_STAGES+1];
  logic                       zf_q [CORDIC_STAGES+1];

  logic signed [ANG_W:0]    zr;
  logic signed [RR_W-1:0]   rr;
  logic signed [OUT_W-1:0]  sat;
  logic signed [OUT_W-1:0]  ang_q;

  always_comb begin
    orv = mx1_q | my1_q;
    for (int c = 0; c < CHUNKS; c++) begin
      nz_c[c]  = |orv[16*c +: 16];
      pos_c[c] = '0;
      for (int b = 0; b < 16; b++) begin
        if (orv[16*c + b]) pos_c[c] = 4'(b);
      end
    end
  end

  always_comb begin
    len_c = '0;
    for (int c = 0; c < CHUNKS; c++) begin
      if (nz2_q[c]) len_c = LEN_W'(16 * c) + LEN_W'(pos2_q[c]) + LEN_W'(1);
    end
  end

  always_comb begin
    if (len3_q > LEN_W'(NORM_W)) begin
      shx = mx3_q >> (len3_q - LEN_W'(NORM_W));
      shy = my3_q >> (len3_q - LEN_W'(NORM_W));
    end else begin
      shx = mx3_q << (LEN_W'(NORM_W) - len3_q);
      shy = my3_q << (LEN_W'(NORM_W) - len3_q);
    end
    xv = $signed({1'b0, shx[NORM_W-1:0]});
    yv = $signed({1'b0, shy[NORM_W-1:0]});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx1_q <= x_i[OPD_W-1] ? $unsigned(-x_i) : $unsigned(x_i);
      my1_q <= y_i[OPD_W-1] ? $unsigned(-y_i) : $unsigned(y_i);
      sx1_q <= x_i[OPD_W-1];
      sy1_q <= y_i[OPD_W-1];

      mx2_q <= mx1_q;
      my2_q <= my1_q;
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      nz2_q <= nz_c;
      for (int c = 0; c < CHUNKS; c++) pos2_q[c] <= pos_c[c];

      mx3_q  <= mx2_q;
      my3_q  <= my2_q;
      sx3_q  <= sx2_q;
      sy3_q  <= sy2_q;
      len3_q <= len_c;

      xs4_q <= sx3_q ? -xv : xv;
      ys4_q <= sy3_q ? -yv : yv;
      zr4_q <= (len3_q == '0);

      // fold the left half plane onto the right
      if (xs4_q < 0) begin
        xc_q[0] <= -CORDIC_W'(xs4_q);
        yc_q[0] <= -CORDIC_W'(ys4_q);
        zc_q[0] <= (ys4_q >= 0) ? ANG_PI : -ANG_PI;
      end else begin
        xc_q[0] <= CORDIC_W'(xs4_q);
        yc_q[0] <= CORDIC_W'(ys4_q);
        zc_q[0] <= '0;
      end
      zf_q[0] <= zr4_q;
    end
  end

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    logic signed [CORDIC_W-1:0] xm, ym, xs, ys;
    logic signed [ANG_W-1:0]    zm;

    always_comb begin
      xm = xc_q[g];
      ym = yc_q[g];
      zm = zc_q[g];
      xs = '0;
      ys = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        xs = xm >>> (g * STEPS_PER_STAGE + k);
        ys = ym >>> (g * STEPS_PER_STAGE + k);
        if (ym >= 0) begin
          xm = xm + ys;
          ym = ym - xs;
          zm = zm + ATAN_TAB[g * STEPS_PER_STAGE + k];
        end else begin
          xm = xm - ys;
          ym = ym + xs;
          zm = zm - ATAN_TAB[g * STEPS_PER_STAGE + k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xc_q[g+1] <= xm;
        yc_q[g+1] <= ym;
        zc_q[g+1] <= zm;
        zf_q[g+1] <= zf_q[g];
      end
    end
  end

  always_comb begin
    zr = $signed({zc_q[CORDIC_STAGES][ANG_W-1], zc_q[CORDIC_STAGES]})
       + (ANG_W+1)'(RND_HALF);
    rr = zr[ANG_W:RND_SH];
    if ((&rr[RR_W-1:OUT_W-1]) || !(|rr[RR_W-1:OUT_W-1])) begin
      sat = rr[OUT_W-1:0];
    end else begin
      sat = rr[RR_W-1] ? OUT_MIN : OUT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= zf_q[CORDIC_STAGES] ? '0 : sat;
    end
  end

  assign ang_o = ang_q;

endmodule
